[hdl/ffra_pkg.sv]
// Shared constants, payload structs and state codes of the first-fit region allocator.
package ffra_pkg;

    localparam int MAX_CELLS       = 1024;
    localparam int CELL_AW         = $clog2(MAX_CELLS);
    localparam int CNT_W           = $clog2(MAX_CELLS + 1);
    localparam int CFG_W           = 11;
    localparam int SIZE_W          = 11;
    localparam int START_W         = 10;
    localparam int TAG_W           = 5;
    localparam int OWNER_W         = 5;
    localparam int LIM_W           = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam logic [CFG_W-1:0]   MEM_CELLS_RESET = CFG_W'(1024);
    localparam logic [OWNER_W-1:0] OWNER_FREE = '0;
    localparam logic [OWNER_W-1:0] OWNER_TOP  = '1;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_RELEASED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RELEASE,
        S_SCAN,
        S_MARK,
        S_RESP
    } state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SIZE_W-1:0]  region_size;
        logic [START_W-1:0] release_start;
        logic [TAG_W-1:0]   owner_tag;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] start_cell;
    } rsp_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [OWNER_W-1:0] data;
    } wr_t;

endpackage

[hdl/ffra_cell_store.sv]
// Cell owner memory with one write port and one registered read port.
module ffra_cell_store (
    input  logic                            clk,
    input  ffra_pkg::wr_t                   wr,
    input  logic                            rd_en,
    input  logic [ffra_pkg::CELL_AW-1:0]    rd_addr,
    output logic [ffra_pkg::OWNER_W-1:0]    rd_data
);

    logic [ffra_pkg::OWNER_W-1:0] mem_reg [ffra_pkg::MAX_CELLS];
    logic [ffra_pkg::OWNER_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/first_fit_region_allocator.sv]
// Top level of the first-fit region allocator: sequencer, scan unit and response register.
//
// Requests arrive on req (valid/ready) and each produces exactly one transaction on rsp.
// An allocate scans the cells upward from 0 one per cycle, counting the run of free
// cells, and stops at the first run of region_size cells below the active size. It
// then marks the run one cell per cycle. A miss scans up to the active size and answers
// with a no-fit status. A release frees one cell per cycle from release_start, up to
// region_size cells, stopping at the active size. A zero-size allocate answers without
// a scan. The memory access bounds all of this: one cell is read or written per cycle,
// and one request is in work at a time. The user must write the memory_cells register
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// After rst_n is released the block sweeps all MAX_CELLS (1024) cells free and holds
// req_ready low until the sweep is done. The response sits in an output register; while
// the receiver stalls, the next request may still be accepted and worked on, and it
// waits for the register to empty before it is presented.
module first_fit_region_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffra_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffra_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [ffra_pkg::CFG_W-1:0]     cfg_wdata
);

    ffra_pkg::state_t                  state_reg, state_next;
    logic [ffra_pkg::CFG_W-1:0]        cfg_reg;
    logic [ffra_pkg::CNT_W-1:0]        addr_reg, addr_next;
    logic [ffra_pkg::SIZE_W-1:0]       rem_reg, rem_next;
    logic [ffra_pkg::SIZE_W-1:0]       size_reg, size_next;
    logic [ffra_pkg::OWNER_W-1:0]      mark_reg, mark_next;
    logic [ffra_pkg::CNT_W-1:0]        run_reg, run_next;
    logic [ffra_pkg::CELL_AW-1:0]      pos_reg, pos_next;
    logic                              rd_valid_reg, rd_valid_next;
    ffra_pkg::rsp_t                    res_reg, res_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    ffra_pkg::rsp_t                    rsp_reg, rsp_next;

    logic [ffra_pkg::LIM_W-1:0]        cfg_ext;
    logic [ffra_pkg::LIM_W-1:0]        limit_w;
    logic [ffra_pkg::CNT_W-1:0]        limit;
    logic [ffra_pkg::LIM_W-1:0]        rstart_ext;
    logic [ffra_pkg::LIM_W-1:0]        start_w;
    logic                              accept;
    logic                              cell_free;
    logic                              found;
    logic                              scan_end;
    logic                              issue;
    logic                              rel_go;
    logic                              rsp_load;
    ffra_pkg::wr_t                     wr;
    logic [ffra_pkg::OWNER_W-1:0]      rd_data;

    ffra_cell_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issue),
        .rd_addr (addr_reg[ffra_pkg::CELL_AW-1:0]),
        .rd_data (rd_data)
    );

    assign cfg_ext    = ffra_pkg::LIM_W'(cfg_reg);
    assign limit_w    = (cfg_ext > ffra_pkg::LIM_W'(ffra_pkg::MAX_CELLS)) ?
                        ffra_pkg::LIM_W'(ffra_pkg::MAX_CELLS) : cfg_ext;
    assign limit      = ffra_pkg::CNT_W'(limit_w);
    assign rstart_ext = ffra_pkg::LIM_W'(req.release_start);

    assign req_ready  = (state_reg == ffra_pkg::S_IDLE);
    assign accept     = req_valid && req_ready;

    assign cell_free  = (rd_data == ffra_pkg::OWNER_FREE);
    assign found      = (state_reg == ffra_pkg::S_SCAN) && rd_valid_reg && cell_free &&
                        (ffra_pkg::LIM_W'(run_reg) + 1'b1 == ffra_pkg::LIM_W'(size_reg));
    assign scan_end   = (state_reg == ffra_pkg::S_SCAN) && !found && (addr_reg >= limit);
    assign issue      = (state_reg == ffra_pkg::S_SCAN) && !found && (addr_reg < limit);
    assign start_w    = ffra_pkg::LIM_W'(pos_reg) + 1'b1 - ffra_pkg::LIM_W'(size_reg);
    assign rel_go     = (state_reg == ffra_pkg::S_RELEASE) && (rem_reg != '0) &&
                        (addr_reg < limit);
    assign rsp_load   = (state_reg == ffra_pkg::S_RESP) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffra_pkg::S_CLEAR:
            begin
                if (addr_reg == ffra_pkg::CNT_W'(ffra_pkg::MAX_CELLS - 1))
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            ffra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == ffra_pkg::CMD_RELEASE)
                    begin
                        state_next = ffra_pkg::S_RELEASE;
                    end
                    else if (req.region_size == '0)
                    begin
                        state_next = ffra_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = ffra_pkg::S_SCAN;
                    end
                end
            end
            ffra_pkg::S_RELEASE:
            begin
                if (!rel_go)
                begin
                    state_next = ffra_pkg::S_RESP;
                end
            end
            ffra_pkg::S_SCAN:
            begin
                if (found)
                begin
                    state_next = ffra_pkg::S_MARK;
                end
                else if (scan_end)
                begin
                    state_next = ffra_pkg::S_RESP;
                end
            end
            ffra_pkg::S_MARK:
            begin
                if (rem_reg == ffra_pkg::SIZE_W'(1))
                begin
                    state_next = ffra_pkg::S_RESP;
                end
            end
            ffra_pkg::S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffra_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        size_next      = size_reg;
        mark_next      = mark_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        rd_valid_next  = issue;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr.en          = 1'b0;
        wr.addr        = addr_reg[ffra_pkg::CELL_AW-1:0];
        wr.data        = ffra_pkg::OWNER_FREE;
        case (state_reg)
            ffra_pkg::S_CLEAR:
            begin
                wr.en     = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            ffra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    size_next = req.region_size;
                    rem_next  = req.region_size;
                    mark_next = (req.owner_tag == ffra_pkg::OWNER_TOP) ?
                                ffra_pkg::OWNER_TOP : ffra_pkg::OWNER_W'(req.owner_tag + 1'b1);
                    run_next  = '0;
                    res_next.start_cell = '0;
                    if (req.cmd == ffra_pkg::CMD_RELEASE)
                    begin
                        addr_next = (rstart_ext >= limit_w) ? limit :
                                    ffra_pkg::CNT_W'(rstart_ext);
                        res_next.status = ffra_pkg::ST_RELEASED;
                    end
                    else
                    begin
                        addr_next = '0;
                        res_next.status = (limit != '0) ? ffra_pkg::ST_PLACED :
                                                          ffra_pkg::ST_NOFIT;
                    end
                end
            end
            ffra_pkg::S_RELEASE:
            begin
                if (rel_go)
                begin
                    wr.en     = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
            end
            ffra_pkg::S_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                    pos_next  = addr_reg[ffra_pkg::CELL_AW-1:0];
                end
                if (rd_valid_reg)
                begin
                    run_next = cell_free ? run_reg + 1'b1 : '0;
                end
                if (found)
                begin
                    addr_next           = ffra_pkg::CNT_W'(start_w);
                    rem_next            = size_reg;
                    res_next.status     = ffra_pkg::ST_PLACED;
                    res_next.start_cell = ffra_pkg::START_W'(start_w);
                end
                else if (scan_end)
                begin
                    res_next.status     = ffra_pkg::ST_NOFIT;
                    res_next.start_cell = '0;
                end
            end
            ffra_pkg::S_MARK:
            begin
                wr.en     = 1'b1;
                wr.data   = mark_reg;
                addr_next = addr_reg + 1'b1;
                rem_next  = rem_reg - 1'b1;
            end
            ffra_pkg::S_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffra_pkg::S_CLEAR;
            cfg_reg       <= ffra_pkg::MEM_CELLS_RESET;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        size_reg <= size_next;
        mark_reg <= mark_next;
        run_reg  <= run_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffra_pkg::S_MARK |-> addr_reg < limit)
        else $error("Marking beyond the active size.");

    a_run_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffra_pkg::S_SCAN |->
            ffra_pkg::LIM_W'(run_reg) < ffra_pkg::LIM_W'(size_reg))
        else $error("Free run count reached the request size without a fit.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request accepted while the previous one is still in work.");

    a_rsp_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ffra_pkg::ST_PLACED ||
                      rsp.status == ffra_pkg::ST_NOFIT ||
                      rsp.status == ffra_pkg::ST_RELEASED)
        else $error("Response transaction carries an undefined status.");

endmodule
